@@ sv/bsrff_pkg.sv @@
`default_nettype none

package bsrff_pkg;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int LINKS_DEF         = 3;
    localparam int WAVELENGTHS_DEF   = 5;

    // field widths
    localparam int BURST_W   = 32;
    localparam int HOP_W     = 4;
    localparam int PLEN_W    = 5;
    localparam int ID_W      = 8;
    localparam int BUSY_BITS = 15;
    localparam int CHANNEL_W = 4;
    localparam int PEER_W    = 10;
    localparam int CFG_IDX_W = 2;

    // peer encoding
    localparam int                NUM_PEERS   = 3;
    localparam logic [PEER_W-1:0] PEER_NONE   = 10'd512;
    localparam logic [1:0]        EDGE_PREFIX = 2'b01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID = 2'd0,
        CFG_PEER0   = 2'd1,
        CFG_PEER1   = 2'd2,
        CFG_PEER2   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OUT_FORWARD  = 3'd0,
        OUT_SENT     = 3'd1,
        OUT_BLOCKED  = 3'd2,
        OUT_BAD_HDR  = 3'd3,
        OUT_NO_PORT  = 3'd4,
        OUT_NO_RESV  = 3'd5,
        OUT_TBL_FULL = 3'd6
    } t_outcome;

    // index width with a floor of one bit
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

@@ sv/bsrff_if.sv @@
`default_nettype none

interface bsrff_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [bsrff_pkg::BURST_W-1:0]       burst_id;
    logic [bsrff_pkg::HOP_W-1:0]         hop_index;
    logic [bsrff_pkg::PLEN_W-1:0]        path_length;
    logic [bsrff_pkg::ID_W-1:0]          path_here;
    logic [bsrff_pkg::ID_W-1:0]          path_next;
    logic [bsrff_pkg::ID_W-1:0]          destination_edge;
    logic [bsrff_pkg::BUSY_BITS-1:0]     channel_busy;
    logic [bsrff_pkg::ID_W-1:0]          service_class;
    logic [bsrff_pkg::ID_W-1:0]          source_edge;

    modport source (
        output valid, action, burst_id, hop_index, path_length, path_here, path_next,
               destination_edge, channel_busy, service_class, source_edge,
        input  ready
    );
    modport sink (
        input  valid, action, burst_id, hop_index, path_length, path_here, path_next,
               destination_edge, channel_busy, service_class, source_edge,
        output ready
    );
endinterface

interface bsrff_out_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          outcome;
    logic [bsrff_pkg::CHANNEL_W-1:0]     out_channel;
    logic [bsrff_pkg::BURST_W-1:0]       result_burst_id;
    logic [bsrff_pkg::PLEN_W-1:0]        next_hop_index;
    logic [bsrff_pkg::ID_W-1:0]          notice_service_class;
    logic [bsrff_pkg::ID_W-1:0]          notice_source_edge;
    logic [bsrff_pkg::ID_W-1:0]          reporting_node;

    modport source (
        output valid, outcome, out_channel, result_burst_id, next_hop_index,
               notice_service_class, notice_source_edge, reporting_node,
        input  ready
    );
    modport sink (
        input  valid, outcome, out_channel, result_burst_id, next_hop_index,
               notice_service_class, notice_source_edge, reporting_node,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/bsrff_cell.sv @@
`default_nettype none

// One reservation entry plus one stage of the search token's path.
module bsrff_cell #(
    parameter int TABLE_ENTRIES = bsrff_pkg::TABLE_ENTRIES_DEF,
    parameter int LINKS         = bsrff_pkg::LINKS_DEF,
    parameter int INDEX         = 0
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  [bsrff_pkg::BURST_W + 2*bsrff_pkg::idx_width(TABLE_ENTRIES)
                  + bsrff_pkg::idx_width(LINKS) + 2:0] i_tok,
    output logic [bsrff_pkg::BURST_W + 2*bsrff_pkg::idx_width(TABLE_ENTRIES)
                  + bsrff_pkg::idx_width(LINKS) + 2:0] o_tok,
    input  wire  [bsrff_pkg::BURST_W + bsrff_pkg::idx_width(TABLE_ENTRIES)
                  + bsrff_pkg::idx_width(LINKS) + 1:0] i_wr
);

    localparam int IW = bsrff_pkg::idx_width(TABLE_ENTRIES);
    localparam int LW = bsrff_pkg::idx_width(LINKS);

    typedef struct packed {
        logic                          valid;
        logic [bsrff_pkg::BURST_W-1:0] burst;
        logic                          hit;
        logic [IW-1:0]                 hit_idx;
        logic [LW-1:0]                 hit_link;
        logic                          free;
        logic [IW-1:0]                 free_idx;
    } t_tok;

    typedef struct packed {
        logic                          en;
        logic [IW-1:0]                 idx;
        logic                          valid;
        logic [bsrff_pkg::BURST_W-1:0] burst;
        logic [LW-1:0]                 link;
    } t_wr;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    t_tok w_in;
    t_tok r_tok;
    t_tok n_tok;
    t_wr  w_wr;

    logic                          r_valid;
    logic [bsrff_pkg::BURST_W-1:0] r_burst;
    logic [LW-1:0]                 r_link;

    assign w_in  = i_tok;
    assign w_wr  = i_wr;
    assign o_tok = r_tok;

    // first match and first free slot win: earlier cells have already claimed
    always_comb begin
        n_tok       = w_in;
        n_tok.valid = w_in.valid;
        if (w_in.valid) begin
            if (r_valid && (r_burst == w_in.burst) && !w_in.hit) begin
                n_tok.hit      = 1'b1;
                n_tok.hit_idx  = MY_IDX;
                n_tok.hit_link = r_link;
            end
            if (!r_valid && !w_in.free) begin
                n_tok.free     = 1'b1;
                n_tok.free_idx = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_wr.en && (w_wr.idx == MY_IDX)) begin
                r_valid <= w_wr.valid;
            end
        end
    end

    // entry payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr.en && (w_wr.idx == MY_IDX) && w_wr.valid) begin
            r_burst <= w_wr.burst;
            r_link  <= w_wr.link;
        end
    end

endmodule

`default_nettype wire

@@ sv/burst_switch_reservation_first_fit_unit.sv @@
// Reservation and first-fit wavelength unit of an optical burst switch core node.
// Input channel i_item (valid/ready): one item per transfer, either a control
// header (action 0) that books a burst on an outgoing link, or a data burst
// (action 1) that frees its booking and takes the lowest idle wavelength.
// Output channel o_result (valid/ready): exactly one result per item.
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data, for the user to write only
// while idle (the unit does not enforce it). The reservation table sits in a
// row of TABLE_ENTRIES cells; a search token walks the row one cell per cycle,
// collecting the first matching and the first free entry, and the result is
// written back in a final write-back state. A header turned away by the checks
// skips the walk. One item is in flight at a time: the next item is taken only
// once the last result has been written back.
// A result waits in the output register while the next item is taken and
// searched; if it is still not taken when the next result is ready, the unit
// holds in its write-back cycle until the output frees up.
// Reset (synchronous, active low) empties the table, sets node_id to 0 and
// all link peers to unconnected.
`default_nettype none

module burst_switch_reservation_first_fit_unit #(
    parameter int TABLE_ENTRIES = bsrff_pkg::TABLE_ENTRIES_DEF,
    parameter int LINKS         = bsrff_pkg::LINKS_DEF,
    parameter int WAVELENGTHS   = bsrff_pkg::WAVELENGTHS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    bsrff_in_if.sink                           i_item,
    bsrff_out_if.source                        o_result,
    input  wire                                i_cfg_we,
    input  wire  [bsrff_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [bsrff_pkg::PEER_W-1:0]       i_cfg_data
);

    localparam int IW     = bsrff_pkg::idx_width(TABLE_ENTRIES);
    localparam int LW     = bsrff_pkg::idx_width(LINKS);
    localparam int CHW    = bsrff_pkg::CHANNEL_W;
    localparam int PW     = bsrff_pkg::PEER_W;
    localparam int BW     = bsrff_pkg::BURST_W;
    localparam int IDW    = bsrff_pkg::ID_W;
    localparam int TOK_W  = BW + 2*IW + LW + 3;
    localparam int WR_W   = BW + IW + LW + 2;

    typedef struct packed {
        logic           valid;
        logic [BW-1:0]  burst;
        logic           hit;
        logic [IW-1:0]  hit_idx;
        logic [LW-1:0]  hit_link;
        logic           free;
        logic [IW-1:0]  free_idx;
    } t_tok;

    typedef struct packed {
        logic           en;
        logic [IW-1:0]  idx;
        logic           valid;
        logic [BW-1:0]  burst;
        logic [LW-1:0]  link;
    } t_wr;

    typedef struct packed {
        bsrff_pkg::t_outcome            outcome;
        logic [CHW-1:0]                 out_channel;
        logic [BW-1:0]                  burst;
        logic [bsrff_pkg::PLEN_W-1:0]   next_hop;
        logic [IDW-1:0]                 svc;
        logic [IDW-1:0]                 src;
        logic [IDW-1:0]                 node;
    } t_res;

    typedef struct packed {
        logic                              action;
        logic [BW-1:0]                     burst_id;
        logic [bsrff_pkg::HOP_W-1:0]       hop_index;
        logic [bsrff_pkg::PLEN_W-1:0]      path_length;
        logic [IDW-1:0]                    path_here;
        logic [IDW-1:0]                    path_next;
        logic [IDW-1:0]                    destination_edge;
        logic [bsrff_pkg::BUSY_BITS-1:0]   channel_busy;
        logic [IDW-1:0]                    service_class;
        logic [IDW-1:0]                    source_edge;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_FINISH
    } t_state;

    // configuration
    logic [IDW-1:0] r_node_id;
    logic [PW-1:0]  r_peer [bsrff_pkg::NUM_PEERS];
    logic [PW-1:0]  w_peer_tab [LINKS];

    // control and payload
    t_state         r_state;
    t_item          r_item;
    logic [LW-1:0]  r_link;
    t_res           r_res;
    t_wr            r_wr;
    logic           r_out_valid;
    t_res           r_out;

    // cell row
    logic [TOK_W-1:0] w_chain [TABLE_ENTRIES+1];
    t_tok             w_head;
    t_tok             w_tail;
    t_wr              w_wr;

    // header checks
    logic           w_bad;
    logic           w_last;
    logic [PW-1:0]  w_want;
    logic           w_link_hit;
    logic [LW-1:0]  w_link;
    t_res           w_rej;

    // decision at the end of the walk
    t_res           w_dec;
    t_wr            w_dec_wr;
    logic           w_ff_hit;
    logic [CHW-1:0] w_ff_ch;

    logic           w_out_free;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
            for (int p = 0; p < bsrff_pkg::NUM_PEERS; p++) begin
                r_peer[p] <= bsrff_pkg::PEER_NONE;
            end
        end else if (i_cfg_we) begin
            unique case (bsrff_pkg::t_cfg_idx'(i_cfg_idx))
                bsrff_pkg::CFG_NODE_ID: r_node_id <= i_cfg_data[IDW-1:0];
                bsrff_pkg::CFG_PEER0:   r_peer[0] <= i_cfg_data;
                bsrff_pkg::CFG_PEER1:   r_peer[1] <= i_cfg_data;
                bsrff_pkg::CFG_PEER2:   r_peer[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // links beyond the peer registers are never connected
    for (genvar g = 0; g < LINKS; g++) begin : g_peer
        if (g < bsrff_pkg::NUM_PEERS) begin : g_reg
            assign w_peer_tab[g] = r_peer[g];
        end else begin : g_none
            assign w_peer_tab[g] = bsrff_pkg::PEER_NONE;
        end
    end

    //------------------------------------------------------------------
    // Header checks and link resolution (CHECK cycle)
    //------------------------------------------------------------------
    assign w_bad  = ({1'b0, r_item.hop_index} >= r_item.path_length) ||
                    (r_item.path_here != r_node_id);
    assign w_last = (({1'b0, r_item.hop_index} + 5'd1) == r_item.path_length);
    // last hop goes to the exit edge, encoded above the core id range
    assign w_want = w_last ? {bsrff_pkg::EDGE_PREFIX, r_item.destination_edge}
                           : {2'b00, r_item.path_next};

    // lowest matching link wins
    always_comb begin
        w_link_hit = 1'b0;
        w_link     = '0;
        for (int l = LINKS - 1; l >= 0; l--) begin
            if (w_peer_tab[l] == w_want) begin
                w_link_hit = 1'b1;
                w_link     = LW'(l);
            end
        end
    end

    // result for a header turned away before the search
    always_comb begin
        w_rej         = '0;
        w_rej.burst   = r_item.burst_id;
        w_rej.outcome = w_bad ? bsrff_pkg::OUT_BAD_HDR : bsrff_pkg::OUT_NO_PORT;
    end

    //------------------------------------------------------------------
    // Cell row
    //------------------------------------------------------------------
    always_comb begin
        w_head          = '0;
        w_head.valid    = (r_state == S_CHECK) &&
                          (r_item.action || (!w_bad && w_link_hit));
        w_head.burst    = r_item.burst_id;
    end

    assign w_chain[0] = w_head;
    assign w_tail     = w_chain[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        bsrff_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .LINKS         (LINKS),
            .INDEX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1]),
            .i_wr    (WR_W'(w_wr))
        );
    end

    //------------------------------------------------------------------
    // First fit over the booked link's wavelengths
    //------------------------------------------------------------------
    always_comb begin
        int   ch;
        logic idle;
        w_ff_hit = 1'b0;
        w_ff_ch  = '0;
        for (int w = WAVELENGTHS - 1; w >= 0; w--) begin
            ch   = int'(w_tail.hit_link) * WAVELENGTHS + w;
            idle = 1'b0;
            // channels beyond the busy field count as absent
            for (int b = 0; b < bsrff_pkg::BUSY_BITS; b++) begin
                if (b == ch) begin
                    idle = !r_item.channel_busy[b];
                end
            end
            if (idle) begin
                w_ff_hit = 1'b1;
                w_ff_ch  = CHW'(ch);
            end
        end
    end

    //------------------------------------------------------------------
    // Decision once the token leaves the last cell
    //------------------------------------------------------------------
    always_comb begin
        w_dec          = '0;
        w_dec.burst    = r_item.burst_id;
        w_dec_wr       = '0;
        w_dec_wr.burst = r_item.burst_id;
        w_dec_wr.link  = r_link;
        if (!r_item.action) begin
            if (w_tail.hit || w_tail.free) begin
                // existing booking is overwritten in place
                w_dec.outcome  = bsrff_pkg::OUT_FORWARD;
                w_dec.next_hop = {1'b0, r_item.hop_index} + 5'd1;
                w_dec_wr.en    = 1'b1;
                w_dec_wr.valid = 1'b1;
                w_dec_wr.idx   = w_tail.hit ? w_tail.hit_idx : w_tail.free_idx;
            end else begin
                w_dec.outcome  = bsrff_pkg::OUT_TBL_FULL;
            end
        end else begin
            if (!w_tail.hit) begin
                w_dec.outcome  = bsrff_pkg::OUT_NO_RESV;
            end else begin
                w_dec_wr.en    = 1'b1;
                w_dec_wr.valid = 1'b0;
                w_dec_wr.idx   = w_tail.hit_idx;
                if (w_ff_hit) begin
                    w_dec.outcome     = bsrff_pkg::OUT_SENT;
                    w_dec.out_channel = w_ff_ch;
                end else begin
                    w_dec.outcome = bsrff_pkg::OUT_BLOCKED;
                    w_dec.svc     = r_item.service_class;
                    w_dec.src     = r_item.source_edge;
                    w_dec.node    = r_node_id;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Sequencer and output register
    //------------------------------------------------------------------
    assign w_out_free = !r_out_valid || o_result.ready;

    // table write lands together with the result transfer into the output register
    always_comb begin
        w_wr    = r_wr;
        w_wr.en = r_wr.en && (r_state == S_FINISH) && w_out_free;
    end

    assign i_item.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wr.en     <= 1'b0;
        end else begin
            // write-back refills the output register itself
            if (r_out_valid && o_result.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_item.action           <= i_item.action;
                        r_item.burst_id         <= i_item.burst_id;
                        r_item.hop_index        <= i_item.hop_index;
                        r_item.path_length      <= i_item.path_length;
                        r_item.path_here        <= i_item.path_here;
                        r_item.path_next        <= i_item.path_next;
                        r_item.destination_edge <= i_item.destination_edge;
                        r_item.channel_busy     <= i_item.channel_busy;
                        r_item.service_class    <= i_item.service_class;
                        r_item.source_edge      <= i_item.source_edge;
                        r_state                 <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_link <= w_link;
                    if (!r_item.action && (w_bad || !w_link_hit)) begin
                        r_res   <= w_rej;
                        r_wr.en <= 1'b0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_tail.valid) begin
                        r_res   <= w_dec;
                        r_wr    <= w_dec_wr;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_wr.en     <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.outcome              = r_out.outcome;
    assign o_result.out_channel          = r_out.out_channel;
    assign o_result.result_burst_id      = r_out.burst;
    assign o_result.next_hop_index       = r_out.next_hop;
    assign o_result.notice_service_class = r_out.svc;
    assign o_result.notice_source_edge   = r_out.src;
    assign o_result.reporting_node       = r_out.node;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
`ifndef ASSERT_OFF
    // a token only leaves the row while the sequencer waits for it
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == S_SEARCH))
        else $error("search token left the cell row outside the search phase");

    // the end of the walk always moves on to write-back
    a_tail_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |=> (r_state == S_FINISH))
        else $error("write-back did not follow the end of the search");

    // table writes happen only from the write-back cycle
    a_write_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> ((r_state == S_FINISH) && w_out_free))
        else $error("table written outside write-back");

    // a sent burst always names a channel inside the busy field
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.outcome == bsrff_pkg::OUT_SENT)) |->
        (int'(o_result.out_channel) < bsrff_pkg::BUSY_BITS))
        else $error("chosen channel outside the busy field");
`endif

endmodule

`default_nettype wire
